/* rtl/tvba_pkg.sv */
// Shared constants, codes and helpers for the texture VRAM bump allocator.
package tvba_pkg;

    localparam int unsigned VRAM_BYTES = 4194304;
    localparam int unsigned PAGE_BYTES = 8192;
    localparam int unsigned MAX_SIDE   = 1024;

    localparam int unsigned ADDR_W  = 23;
    localparam int unsigned SIDE_W  = 12;
    localparam int unsigned ARITH_W = 30;
    localparam int unsigned UNIT_W  = 8;

    // padding grids: direct 64x32 px at 4 bytes, indexed 128x64 px at 1 byte
    localparam int unsigned D_GRID_W   = 64;
    localparam int unsigned D_GRID_H   = 32;
    localparam int unsigned D_PIX_B    = 4;
    localparam int unsigned I_GRID_W   = 128;
    localparam int unsigned I_GRID_H   = 64;
    localparam int unsigned D_TILE_B   = D_GRID_W * D_GRID_H * D_PIX_B;
    localparam int unsigned I_TILE_B   = I_GRID_W * I_GRID_H;
    localparam int unsigned BLK_B      = 256;
    localparam int unsigned PAL_B      = 1024;
    localparam int unsigned BW_UNIT    = 64;
    localparam int unsigned I_BW_SCALE = I_GRID_W / BW_UNIT;

    localparam logic [1:0] REQ_DIRECT  = 2'd0;
    localparam logic [1:0] REQ_INDEXED = 2'd1;
    localparam logic [1:0] REQ_RESET   = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_MISALIGN = 3'd2;
    localparam logic [2:0] ST_MULTIPLE = 3'd3;
    localparam logic [2:0] ST_NO_MEM   = 3'd4;

    typedef logic [2:0] status_t;

    // ceiling log2, capped at 15
    function automatic logic [3:0] clog2_cap(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] m;
        logic [4:0]        r;
        m = v - SIDE_W'(1);
        r = 5'd0;
        if (v > SIDE_W'(1)) begin
            for (int i = 0; i < SIDE_W; i++) begin
                if (m[i]) r = 5'(i + 1);
            end
        end
        clog2_cap = (r > 5'd15) ? 4'd15 : r[3:0];
    endfunction

endpackage

/* rtl/texture_vram_bump_allocator_core.sv */
// Texture VRAM bump allocator: request register, allocation logic, result register.
//
// Each request (allocate direct, allocate indexed, or reset cursor) produces exactly one
// result. A request is captured in the input register, evaluated by combinational logic
// (checks, grid padding, page alignment, fit test) and written to the result register while
// the cursor updates in the same cycle, so while m_ready holds a new request can be taken
// every cycle and throughput is one request per cycle; m_ready low stalls the step.
// The cursor resets to 0 and is loaded from texture_start only by a reset-cursor request.
// texture_start resets to 0 and is loaded by the config write port, which is always ready.
module texture_vram_bump_allocator_core
    import tvba_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic [SIDE_W-1:0]   s_tex_width,
    input  logic [SIDE_W-1:0]   s_tex_height,
    input  logic [3:0]          s_source_low_bits,
    input  logic [3:0]          s_palette_low_bits,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [13:0]         m_texture_block,
    output logic [13:0]         m_palette_block,
    output logic [4:0]          m_row_pitch,
    output logic [3:0]          m_width_exp,
    output logic [3:0]          m_height_exp,
    output logic                m_is_indexed,
    output logic [ADDR_W-1:0]   m_free_bytes
);

    logic [ADDR_W-1:0] texture_start_reg;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;

    logic              in_valid_reg;
    logic [1:0]        req_type_reg;
    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [3:0]        src_bits_reg, pal_bits_reg;

    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic [13:0]       tblk_reg, tblk_next;
    logic [13:0]       pblk_reg, pblk_next;
    logic [4:0]        bw_reg, bw_next;
    logic [3:0]        wl_reg, wl_next;
    logic [3:0]        hl_reg, hl_next;
    logic              idx_reg, idx_next;
    logic [ADDR_W-1:0] free_reg, free_next;

    logic              step;
    logic              indexed;
    logic              is_alloc;
    logic [3:0]        low_prod;
    logic [UNIT_W-1:0] units_w, units_h;
    logic [2*UNIT_W-1:0] units;
    logic [ARITH_W-1:0] bytes, cur, pcur, end_addr;

    assign cfg_ready = 1'b1;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            texture_start_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            texture_start_reg <= cfg_data;
        end
    end

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            req_type_reg <= s_req_type;
            width_reg    <= s_tex_width;
            height_reg   <= s_tex_height;
            src_bits_reg <= s_source_low_bits;
            pal_bits_reg <= s_palette_low_bits;
        end
    end

    assign indexed  = (req_type_reg == REQ_INDEXED);
    assign is_alloc = (req_type_reg == REQ_DIRECT) || indexed;

    // only the low nibble of w*h matters for the 16-byte multiple check
    assign low_prod = 4'(width_reg[3:0] * height_reg[3:0]);

    always_comb begin
        if (indexed) begin
            units_w = UNIT_W'((13'(width_reg) + 13'(I_GRID_W - 1)) / I_GRID_W);
            units_h = UNIT_W'((13'(height_reg) + 13'(I_GRID_H - 1)) / I_GRID_H);
        end else begin
            units_w = UNIT_W'((13'(width_reg) + 13'(D_GRID_W - 1)) / D_GRID_W);
            units_h = UNIT_W'((13'(height_reg) + 13'(D_GRID_H - 1)) / D_GRID_H);
        end
    end

    assign units = units_w * units_h;
    assign bytes = indexed ? ARITH_W'(units) * ARITH_W'(I_TILE_B)
                           : ARITH_W'(units) * ARITH_W'(D_TILE_B);

    assign cur  = (ARITH_W'(cursor_reg) + ARITH_W'(PAGE_BYTES - 1))
                  & ~ARITH_W'(PAGE_BYTES - 1);
    assign pcur = (cur + bytes + ARITH_W'(BLK_B - 1)) & ~ARITH_W'(BLK_B - 1);
    assign end_addr = indexed ? pcur + ARITH_W'(PAL_B) : cur + bytes;

    always_comb begin
        status_next = ST_OK;
        tblk_next   = '0;
        pblk_next   = '0;
        bw_next     = '0;
        wl_next     = '0;
        hl_next     = '0;
        idx_next    = 1'b0;
        cursor_next = cursor_reg;

        if (req_type_reg == REQ_RESET) begin
            cursor_next = texture_start_reg;
        end else if (is_alloc) begin
            if (width_reg == '0 || height_reg == '0 ||
                width_reg > SIDE_W'(MAX_SIDE) || height_reg > SIDE_W'(MAX_SIDE)) begin
                status_next = ST_BAD_SIZE;
            end else if (src_bits_reg != 4'd0 || (indexed && pal_bits_reg != 4'd0)) begin
                status_next = ST_MISALIGN;
            end else if (indexed ? (low_prod != 4'd0) : (low_prod[1:0] != 2'd0)) begin
                status_next = ST_MULTIPLE;
            end else if (end_addr > ARITH_W'(VRAM_BYTES)) begin
                status_next = ST_NO_MEM;
            end else begin
                tblk_next   = cur[21:8];
                pblk_next   = indexed ? pcur[21:8] : 14'd0;
                bw_next     = indexed ? 5'(units_w * I_BW_SCALE) : units_w[4:0];
                wl_next     = clog2_cap(width_reg);
                hl_next     = clog2_cap(height_reg);
                idx_next    = indexed;
                cursor_next = end_addr[ADDR_W-1:0];
            end
        end

        if ({1'b0, cursor_next} >= 24'(VRAM_BYTES)) begin
            free_next = '0;
        end else begin
            free_next = ADDR_W'(24'(VRAM_BYTES) - {1'b0, cursor_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (step) begin
            cursor_reg <= cursor_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (step) begin
            status_reg <= status_next;
            tblk_reg   <= tblk_next;
            pblk_reg   <= pblk_next;
            bw_reg     <= bw_next;
            wl_reg     <= wl_next;
            hl_reg     <= hl_next;
            idx_reg    <= idx_next;
            free_reg   <= free_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_texture_block = tblk_reg;
    assign m_palette_block = pblk_reg;
    assign m_row_pitch     = bw_reg;
    assign m_width_exp     = wl_reg;
    assign m_height_exp    = hl_reg;
    assign m_is_indexed    = idx_reg;
    assign m_free_bytes    = free_reg;

    // a failed allocation must leave the cursor alone
    a_err_keeps_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        step && status_next != ST_OK |=> cursor_reg == $past(cursor_reg))
        else $error("cursor moved on failed allocation");

    a_err_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_texture_block == 14'd0 &&
            m_palette_block == 14'd0 && !m_is_indexed)
        else $error("error result carries address fields");

    a_palette_above_texture: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_indexed |-> m_palette_block > m_texture_block)
        else $error("palette not above texture");

    a_empty_takes_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty request register refuses request");

    a_result_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("evaluated request lost");

endmodule
